/* sv/mrmc_pkg.sv */
// Shared constants and types for the min/max-rejection mean combiner.
`timescale 1ns / 1ps
package mrmc_pkg;

    // Frames per pixel that the sorting chain holds, and the sample width.
    localparam int MAX_FRAMES  = 32;
    localparam int SAMPLE_BITS = 32;

    // Derived widths.
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);   // holds 0..MAX_FRAMES
    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int SUM_W = SAMPLE_BITS + IDX_W;      // sum of MAX_FRAMES samples
    localparam int TW    = CNT_W + 2;                // signed rank arithmetic
    localparam int DC_W  = $clog2(SUM_W + 1);        // divider step counter

    // Configuration register widths and indexes.
    localparam int NF_W      = 6;
    localparam int RJ_W      = 5;
    localparam int FP_W      = 25;
    localparam int POS_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_FRAME_PIXELS = 16777216;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd3;

    // Commands broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic clear;    // drop all held values
        logic insert;   // insert the broadcast sample in sorted order
        logic shift;    // move every value one cell toward cell 0
    } t_cell_ctrl;

endpackage

/* sv/mrmc_cell.sv */
// One cell of the insertion-sorting chain: holds one value of the current pixel.
`timescale 1ns / 1ps
module mrmc_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mrmc_pkg::t_cell_ctrl                   i_ctrl,
    input  logic signed [mrmc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [mrmc_pkg::SAMPLE_BITS-1:0] i_left_val,
    input  logic                                   i_left_valid,
    input  logic                                   i_left_gt,
    input  logic signed [mrmc_pkg::SAMPLE_BITS-1:0] i_right_val,
    input  logic                                   i_right_valid,
    output logic signed [mrmc_pkg::SAMPLE_BITS-1:0] o_val,
    output logic                                   o_valid,
    output logic                                   o_gt
);
    import mrmc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic                          r_valid;
    logic                          w_take;

    // The chain stays ascending, so the cells holding values above the sample
    // form a contiguous tail; each of them hands its value one cell to the right.
    assign o_gt   = r_valid && (r_val > i_sample);
    // The sample lands in the first cell that is either above it or empty.
    assign w_take = o_gt || (!r_valid && i_left_valid);
    assign o_val  = r_val;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_right_valid;
        end else if (i_ctrl.insert && (i_left_gt || w_take)) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_val <= i_right_val;
        end else if (i_ctrl.insert) begin
            if (i_left_gt) begin
                r_val <= i_left_val;
            end else if (w_take) begin
                r_val <= i_sample;
            end
        end
    end

endmodule

/* sv/mrmc_div.sv */
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module mrmc_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [mrmc_pkg::SUM_W-1:0]       i_dividend,
    input  logic [mrmc_pkg::CNT_W-1:0]              i_divisor,
    output logic                                    o_busy,
    output logic signed [mrmc_pkg::SAMPLE_BITS-1:0] o_quot
);
    import mrmc_pkg::*;

    logic                   r_busy;
    logic [DC_W-1:0]        r_cnt;
    logic [SUM_W-1:0]       r_q;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_den;
    logic                   r_neg;
    logic [CNT_W:0]         w_trial;
    logic                   w_fit;
    logic [SAMPLE_BITS-1:0] w_mag;

    // The dividend's magnitude is taken as unsigned, so the most negative sum
    // still has a correct magnitude.
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_mag   = r_q[SAMPLE_BITS-1:0];
    assign o_quot  = r_neg ? -w_mag : w_mag;
    assign o_busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DC_W'(1);
            if (r_cnt == DC_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_q   <= i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[SUM_W-2:0], w_fit};
            if (w_fit) begin
                r_rem <= CNT_W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[CNT_W-1:0];
            end
        end
    end

endmodule

/* sv/minmax_reject_mean_combine_unit.sv */
// Top level: trimmed-mean frame combiner built on a chain of sorting cells.
`timescale 1ns / 1ps
// Per pixel: the sample beats are taken, the chain is drained through the adder, the
//   divider runs (skipped when every value is rejected) and the result is handed off.
//   The next pixel's beats are taken only once the result is in the output register.
// Reset (synchronous, active low) restores the register defaults, empties the chain
//   and restarts at pixel 0 of a frame.
module minmax_reject_mean_combine_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [mrmc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mrmc_pkg::FP_W-1:0]             i_cfg_data,
    // Sample stream. tdata: [31:0] sample.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [mrmc_pkg::SAMPLE_BITS-1:0]      i_s_axis_tdata,
    // Result stream. tdata: [31:0] mean. tuser: [0] no_kept_error.
    // tlast: frame_end.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [mrmc_pkg::SAMPLE_BITS-1:0]      o_m_axis_tdata,
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);
    import mrmc_pkg::*;

    typedef enum logic [3:0] {
        S_COLLECT = 4'b0001,   // taking sample beats into the chain
        S_DRAIN   = 4'b0010,   // shifting sorted values out through the adder
        S_DIV     = 4'b0100,   // waiting for the divider
        S_DONE    = 4'b1000    // result ready, waiting for the output register
    } t_state;

    // Configuration.
    logic [NF_W-1:0]  r_num_frames;
    logic [RJ_W-1:0]  r_rej_low;
    logic [RJ_W-1:0]  r_rej_high;
    logic [FP_W-1:0]  r_frame_pixels;

    // Control.
    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rank;
    logic [POS_W-1:0] r_pix_pos;
    logic             r_err;
    logic signed [SUM_W-1:0] r_acc;

    // Output register.
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic                   r_out_err;
    logic                   r_out_fend;

    logic [CNT_W-1:0]  w_frames;
    logic [FP_W-1:0]   w_pixels;
    logic              w_s_accept;
    logic              w_last_sample;
    logic              w_restart;
    logic              w_rank_in;
    logic              w_drain_end;
    logic signed [TW-1:0]    w_kept;
    logic              w_no_kept;
    logic signed [SUM_W-1:0] w_addend;
    logic signed [SUM_W-1:0] w_acc_next;
    logic              w_div_start;
    logic              w_div_busy;
    logic signed [SAMPLE_BITS-1:0] w_quot;
    logic              w_out_free;
    logic              w_fend;
    t_cell_ctrl        w_ctrl;

    logic signed [SAMPLE_BITS-1:0] w_val   [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]         w_valid;
    logic [MAX_FRAMES-1:0]         w_gt;

    // Register values outside their range act as the nearest legal value.
    always_comb begin
        if (r_num_frames == '0) begin
            w_frames = CNT_W'(1);
        end else if (int'(r_num_frames) > MAX_FRAMES) begin
            w_frames = CNT_W'(MAX_FRAMES);
        end else begin
            w_frames = CNT_W'(r_num_frames);
        end
    end

    always_comb begin
        if (r_frame_pixels == '0) begin
            w_pixels = FP_W'(1);
        end else if (r_frame_pixels > FP_W'(MAX_FRAME_PIXELS)) begin
            w_pixels = FP_W'(MAX_FRAME_PIXELS);
        end else begin
            w_pixels = r_frame_pixels;
        end
    end

    assign o_s_axis_tready = (r_state == S_COLLECT);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last_sample   = (r_count + CNT_W'(1)) == w_frames;

    // Changing the frame count or frame size empties the chain; while collecting it also
    // drops the partial pixel and restarts at the first pixel of a frame.
    assign w_restart = i_cfg_we &&
                       (i_cfg_index == REG_NUM_FRAMES || i_cfg_index == REG_FRAME_PIXELS);

    assign w_ctrl.clear  = w_restart;
    assign w_ctrl.insert = w_s_accept;
    assign w_ctrl.shift  = (r_state == S_DRAIN);

    // The sorting chain. Cell 0 holds the smallest value; during the drain
    // every value moves one cell toward cell 0 each cycle, so cell 0 presents
    // the sorted values in ascending order, one per cycle.
    generate
        for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] w_lval;
            logic signed [SAMPLE_BITS-1:0] w_rval;
            logic                          w_lvalid;
            logic                          w_lgt;
            logic                          w_rvalid;

            if (g == 0) begin : g_head
                assign w_lval   = '0;
                assign w_lvalid = 1'b1;
                assign w_lgt    = 1'b0;
            end else begin : g_body
                assign w_lval   = w_val[g-1];
                assign w_lvalid = w_valid[g-1];
                assign w_lgt    = w_gt[g-1];
            end

            if (g == MAX_FRAMES - 1) begin : g_tail
                assign w_rval   = '0;
                assign w_rvalid = 1'b0;
            end else begin : g_inner
                assign w_rval   = w_val[g+1];
                assign w_rvalid = w_valid[g+1];
            end

            mrmc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_sample      (i_s_axis_tdata),
                .i_left_val    (w_lval),
                .i_left_valid  (w_lvalid),
                .i_left_gt     (w_lgt),
                .i_right_val   (w_rval),
                .i_right_valid (w_rvalid),
                .o_val         (w_val[g]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g])
            );
        end
    endgenerate

    // Kept count and the window of ranks that enter the sum.
    assign w_kept    = TW'(w_frames) - TW'(r_rej_low) - TW'(r_rej_high);
    assign w_no_kept = w_kept[TW-1] || (w_kept == '0);
    assign w_rank_in = (TW'(r_rank) >= TW'(r_rej_low)) &&
                       ((TW'(r_rank) + TW'(r_rej_high)) < TW'(w_frames));

    assign w_addend    = w_rank_in ? {{IDX_W{w_val[0][SAMPLE_BITS-1]}}, w_val[0]} : '0;
    assign w_acc_next  = r_acc + w_addend;
    assign w_drain_end = (r_state == S_DRAIN) && (r_rank + CNT_W'(1) == w_frames);
    assign w_div_start = w_drain_end && !w_no_kept;

    mrmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc_next),
        .i_divisor  (w_kept[CNT_W-1:0]),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_fend     = ({1'b0, r_pix_pos} + FP_W'(1)) >= w_pixels;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_frames   <= NF_W'(1);
            r_rej_low      <= '0;
            r_rej_high     <= '0;
            r_frame_pixels <= FP_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_FRAMES:   r_num_frames   <= i_cfg_data[NF_W-1:0];
                REG_REJECT_LOW:   r_rej_low      <= i_cfg_data[RJ_W-1:0];
                REG_REJECT_HIGH:  r_rej_high     <= i_cfg_data[RJ_W-1:0];
                REG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer for one pixel: collect, drain and sum, divide (skipped when no value is kept), hand off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_COLLECT;
            r_count   <= '0;
            r_rank    <= '0;
            r_pix_pos <= '0;
            r_err     <= 1'b0;
        end else begin
            case (r_state)
                S_COLLECT: begin
                    if (w_restart) begin
                        r_count   <= '0;
                        r_pix_pos <= '0;
                    end else if (w_s_accept) begin
                        if (w_last_sample) begin
                            r_count <= '0;
                            r_rank  <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    r_rank <= r_rank + CNT_W'(1);
                    if (w_drain_end) begin
                        r_err   <= w_no_kept;
                        r_state <= w_no_kept ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_pix_pos <= w_fend ? '0 : r_pix_pos + POS_W'(1);
                        r_state   <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    // Running sum of the kept ranks.
    always_ff @(posedge i_clk) begin
        if (w_s_accept && w_last_sample) begin
            r_acc <= '0;
        end else if (r_state == S_DRAIN) begin
            r_acc <= w_acc_next;
        end
    end

    // Output register: the next pixel's beats are taken while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_mean <= r_err ? '0 : w_quot;
            r_out_err  <= r_err;
            r_out_fend <= w_fend;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_mean;
    assign o_m_axis_tuser  = r_out_err;
    assign o_m_axis_tlast  = r_out_fend;

`ifndef NO_ASSERTIONS
    // The chain holds exactly as many values as beats taken for this pixel.
    a_chain_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLLECT) |-> ($countones(w_valid) == int'(r_count)))
        else $error("sorting chain fill does not match the beat count");

    // The last beat of a pixel starts the drain.
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && w_last_sample && !w_restart) |=> (r_state == S_DRAIN))
        else $error("drain did not start after the last beat of a pixel");

    // The divider runs only while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> !w_div_busy)
        else $error("divider busy outside the divide step");

    // The chain is empty once a pixel has drained.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_DONE) |-> (w_valid == '0))
        else $error("values left in the chain after the drain");
`endif

endmodule
